// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define KMC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("kmc assertion failed");
// condition must never be seen outside reset
`define KMC_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("kmc forbidden condition seen");
`else
`define KMC_ASSERT(label, clk, rst_n, prop)
`define KMC_NEVER(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/kmc_pkg.sv
`timescale 1ns / 1ps

package kmc_pkg;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_BUMP = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } back_state_e;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 4;
  localparam int unsigned KLEN_W      = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_IN_W   = 16;
  localparam int unsigned IDX_OUT_W   = 16;
  localparam int unsigned COUNT_OUT_W = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_KMER_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_REVERSE = 2'd1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;

  localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  // control part of one queued command
  typedef struct packed {
    cmd_kind_e kind;
    logic      do_rev;
    logic      window_full;
  } cmd_ctrl_t;

  // msb set: not a base; low bits: 2-bit base code
  function automatic logic [2:0] base_code(input logic [BYTE_W-1:0] ch);
    logic [2:0] code;
    case (ch)
      8'h41, 8'h61: code = 3'b000;
      8'h43, 8'h63: code = 3'b001;
      8'h47, 8'h67: code = 3'b010;
      8'h54, 8'h74: code = 3'b011;
      default:      code = 3'b100;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/dna_kmer_histogram_counter_unit.sv
`timescale 1ns / 1ps

// path: a result passes the command queue, then the stage-two and result registers of the engine
// throughput: 1 item per cycle while the result side takes results; a counted base with reverse
//   strand on is issued twice, as the single histogram ram does one read-modify-write per cycle
// reset: async active low; then a clearing sweep over all 4**MAX_KMER bins (65536 by default)
//   zeroes the histogram with in_ready_o low; config writes are taken throughout
module dna_kmer_histogram_counter_unit import kmc_pkg::*; #(
  parameter int unsigned MAX_KMER   = 8,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [BYTE_W-1:0]      stream_byte_i,
  input  logic [ADDR_IN_W-1:0]   bin_address_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   window_full_o,
  output logic [IDX_OUT_W-1:0]   forward_index_o,
  output logic [IDX_OUT_W-1:0]   reverse_index_o,
  output logic [COUNT_OUT_W-1:0] bin_count_o
);

  // histogram address width: two bits per base
  localparam int unsigned AW     = 2 * MAX_KMER;
  localparam int unsigned CTRL_W = $bits(cmd_ctrl_t);
  localparam int unsigned CMD_W  = CTRL_W + 2 * AW;

  // configuration registers
  logic [KLEN_W-1:0] kmer_length_q, kmer_length_d;
  logic              count_rev_q, count_rev_d;

  logic              in_xfer, cfg_xfer;
  logic              fifo_full, fifo_empty, fifo_pop, clearing;

  // command from the parser and at the queue head
  cmd_ctrl_t         cmd_ctrl, head_ctrl;
  logic [AW-1:0]     cmd_fwd, cmd_rev, head_fwd, head_rev;
  logic [CMD_W-1:0]  head_data;

  // result from the engine at native widths
  logic                  res_wf;
  logic [AW-1:0]         res_fwd, res_rev;
  logic [COUNT_BITS-1:0] res_count;

  // config is always taken; the user must write it only while the block is idle: not enforced
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    kmer_length_d = kmer_length_q;
    count_rev_d   = count_rev_q;
    if (cfg_xfer) begin
      case (cfg_index_i)
        REG_KMER_LENGTH:   kmer_length_d = cfg_data_i[KLEN_W-1:0];
        REG_COUNT_REVERSE: count_rev_d   = cfg_data_i[0];
        default:           kmer_length_d = kmer_length_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KLEN_RESET;
      count_rev_q   <= 1'b0;
    end else begin
      kmer_length_q <= kmer_length_d;
      count_rev_q   <= count_rev_d;
    end
  end

  // the parser takes a byte whenever the queue has room and the sweep is done
  assign in_ready_o = !fifo_full && !clearing;
  assign in_xfer    = in_valid_i && in_ready_o;

  kmc_front #(
    .MAX_KMER (MAX_KMER)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_xfer),
    .opcode_i        (opcode_i),
    .stream_byte_i   (stream_byte_i),
    .bin_address_i   (bin_address_i),
    .kmer_length_i   (kmer_length_q),
    .count_reverse_i (count_rev_q),
    .cmd_ctrl_o      (cmd_ctrl),
    .cmd_fwd_o       (cmd_fwd),
    .cmd_rev_o       (cmd_rev)
  );

  // queue decouples parsing from the histogram pipe
  kmc_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .data_i  ({cmd_ctrl, cmd_fwd, cmd_rev}),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (head_data)
  );

  assign head_ctrl = cmd_ctrl_t'(head_data[CMD_W-1 -: CTRL_W]);
  assign head_fwd  = head_data[2*AW-1 -: AW];
  assign head_rev  = head_data[AW-1:0];

  // engine: clears bins after reset, bumps bins, serves reads, holds the result register
  kmc_back #(
    .AW         (AW),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (!fifo_empty),
    .head_ctrl_i       (head_ctrl),
    .head_fwd_i        (head_fwd),
    .head_rev_i        (head_rev),
    .pop_o             (fifo_pop),
    .clearing_o        (clearing),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_window_full_o (res_wf),
    .out_fwd_o         (res_fwd),
    .out_rev_o         (res_rev),
    .out_count_o       (res_count)
  );

  assign window_full_o = res_wf;

  // indices are reported in a 16-bit field
  if (AW >= IDX_OUT_W) begin : g_idx_trunc
    assign forward_index_o = res_fwd[IDX_OUT_W-1:0];
    assign reverse_index_o = res_rev[IDX_OUT_W-1:0];
  end else begin : g_idx_ext
    assign forward_index_o = IDX_OUT_W'(res_fwd);
    assign reverse_index_o = IDX_OUT_W'(res_rev);
  end

  // wide counters saturate into the 32-bit result field
  if (COUNT_BITS > COUNT_OUT_W) begin : g_cnt_sat
    assign bin_count_o = (|res_count[COUNT_BITS-1:COUNT_OUT_W]) ?
                         {COUNT_OUT_W{1'b1}} : res_count[COUNT_OUT_W-1:0];
  end else begin : g_cnt_ext
    assign bin_count_o = COUNT_OUT_W'(res_count);
  end

endmodule

// File: rtl/kmc_ram.sv
`timescale 1ns / 1ps

// simple dual port ram, depth 2**ADDR_W, registered read
module kmc_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_W];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/kmc_fifo.sv
`timescale 1ns / 1ps

// small command queue between parser and counter engine
module kmc_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W:0]    rd_ptr_q, rd_ptr_d;

  assign full_o  = (wr_ptr_q[PTR_W] != rd_ptr_q[PTR_W]) &&
                   (wr_ptr_q[PTR_W-1:0] == rd_ptr_q[PTR_W-1:0]);
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign data_o  = mem_q[rd_ptr_q[PTR_W-1:0]];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + (PTR_W + 1)'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[PTR_W-1:0]] <= data_i;
    end
  end

endmodule

// File: rtl/kmc_front.sv
`timescale 1ns / 1ps

// fasta parser: header skip, base coding, k-mer windows, command build
module kmc_front import kmc_pkg::*; #(
  parameter int unsigned MAX_KMER = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    opcode_i,
  input  logic [BYTE_W-1:0]       stream_byte_i,
  input  logic [ADDR_IN_W-1:0]    bin_address_i,
  input  logic [KLEN_W-1:0]       kmer_length_i,
  input  logic                    count_reverse_i,
  output cmd_ctrl_t               cmd_ctrl_o,
  output logic [2*MAX_KMER-1:0]   cmd_fwd_o,
  output logic [2*MAX_KMER-1:0]   cmd_rev_o
);

  localparam int unsigned AW    = 2 * MAX_KMER;
  localparam int unsigned RUN_W = $clog2(MAX_KMER + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_KMER);

  logic [AW-1:0]    fwd_q, fwd_d, rev_q, rev_d;
  logic [AW-1:0]    fwd_shift, rev_shift, fwd_mask, read_addr;
  logic [RUN_W-1:0] run_q, run_d, run_inc, k_eff;
  logic             hdr_q, hdr_d;
  logic [2:0]       code;

  if (AW <= ADDR_IN_W) begin : g_addr_narrow
    assign read_addr = bin_address_i[AW-1:0];
  end else begin : g_addr_wide
    assign read_addr = AW'(bin_address_i);
  end

  assign code      = base_code(stream_byte_i);
  assign fwd_shift = (fwd_q << 2) | AW'(code[1:0]);
  assign rev_shift = (rev_q >> 2) | (AW'(~code[1:0]) << (AW - 2));
  assign run_inc   = (run_q < RUN_MAX) ? run_q + RUN_W'(1) : run_q;
  assign fwd_mask  = ~({AW{1'b1}} << {k_eff, 1'b0});

  // length register clamped into 1..MAX_KMER
  always_comb begin
    if (kmer_length_i == '0) begin
      k_eff = RUN_W'(1);
    end else if (32'(kmer_length_i) > MAX_KMER) begin
      k_eff = RUN_MAX;
    end else begin
      k_eff = RUN_W'(kmer_length_i);
    end
  end

  always_comb begin
    fwd_d = fwd_q;
    rev_d = rev_q;
    run_d = run_q;
    hdr_d = hdr_q;
    cmd_ctrl_o.kind        = CMD_NONE;
    cmd_ctrl_o.do_rev      = 1'b0;
    cmd_ctrl_o.window_full = 1'b0;
    cmd_fwd_o = '0;
    cmd_rev_o = '0;
    if (opcode_i == OP_READ) begin
      cmd_ctrl_o.kind = CMD_READ;
      cmd_fwd_o       = read_addr;
    end else if (hdr_q) begin
      if (stream_byte_i == CH_NEWLINE) begin
        hdr_d = 1'b0;
      end
    end else if (stream_byte_i == CH_HEADER) begin
      hdr_d = 1'b1;
      fwd_d = '0;
      rev_d = '0;
      run_d = '0;
    end else if (stream_byte_i == CH_NEWLINE) begin
      hdr_d = hdr_q;
    end else if (code[2]) begin
      fwd_d = '0;
      rev_d = '0;
      run_d = '0;
    end else begin
      fwd_d = fwd_shift;
      rev_d = rev_shift;
      run_d = run_inc;
      if (run_inc >= k_eff) begin
        cmd_ctrl_o.kind        = CMD_BUMP;
        cmd_ctrl_o.do_rev      = count_reverse_i;
        cmd_ctrl_o.window_full = 1'b1;
        cmd_fwd_o = fwd_shift & fwd_mask;
        cmd_rev_o = rev_shift >> {RUN_MAX - k_eff, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= '0;
      rev_q <= '0;
      run_q <= '0;
      hdr_q <= 1'b0;
    end else if (accept_i) begin
      fwd_q <= fwd_d;
      rev_q <= rev_d;
      run_q <= run_d;
      hdr_q <= hdr_d;
    end
  end

endmodule

// File: rtl/kmc_back.sv
`timescale 1ns / 1ps

// counter engine: clearing sweep, read-modify-write pipe, result register
module kmc_back import kmc_pkg::*; #(
  parameter int unsigned AW         = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  cmd_ctrl_t             head_ctrl_i,
  input  logic [AW-1:0]         head_fwd_i,
  input  logic [AW-1:0]         head_rev_i,
  output logic                  pop_o,
  output logic                  clearing_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_window_full_o,
  output logic [AW-1:0]         out_fwd_o,
  output logic [AW-1:0]         out_rev_o,
  output logic [COUNT_BITS-1:0] out_count_o
);

`include "assert_macros.svh"

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  back_state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          phase_q, phase_d;

  // stage two: memory data returns, write back, result
  logic                  s2_valid_q;
  cmd_kind_e             s2_kind_q;
  logic                  s2_last_q;
  logic [AW-1:0]         s2_addr_q;
  logic                  s2_bypass_q;
  logic [COUNT_BITS-1:0] s2_bypass_data_q;
  logic                  s2_wf_q;
  logic [AW-1:0]         s2_fwd_q, s2_rev_q;

  logic                  out_valid_q;
  logic                  out_wf_q;
  logic [AW-1:0]         out_fwd_q, out_rev_q;
  logic [COUNT_BITS-1:0] out_count_q;

  logic                  out_free, s2_fire, s2_free;
  logic                  issue, issue_last, double_op, rd_en, wr_en;
  logic [AW-1:0]         issue_addr, wr_addr;
  logic [COUNT_BITS-1:0] rd_data, eff, inc, wr_data;

  kmc_ram #(
    .WIDTH  (COUNT_BITS),
    .ADDR_W (AW)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_addr),
    .rd_data_o (rd_data)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign s2_fire  = s2_valid_q && (!s2_last_q || out_free);
  assign s2_free  = !s2_valid_q || s2_fire;

  // a read issued alongside a write to the same bin takes the written value
  assign eff = s2_bypass_q ? s2_bypass_data_q : rd_data;
  assign inc = (eff == COUNT_MAX) ? eff : eff + COUNT_BITS'(1);

  assign double_op  = (head_ctrl_i.kind == CMD_BUMP) && head_ctrl_i.do_rev;
  assign issue      = (state_q == ST_RUN) && head_valid_i && s2_free;
  assign issue_last = !double_op || phase_q;
  assign issue_addr = (double_op && phase_q) ? head_rev_i : head_fwd_i;
  assign rd_en      = issue && (head_ctrl_i.kind != CMD_NONE);
  assign pop_o      = issue && issue_last;
  assign phase_d    = issue ? (double_op && !phase_q) : phase_q;

  assign wr_en   = (state_q == ST_CLEAR) || (s2_fire && (s2_kind_q == CMD_BUMP));
  assign wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q : s2_addr_q;
  assign wr_data = (state_q == ST_CLEAR) ? '0 : inc;

  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (&clr_cnt_q) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      phase_q     <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      phase_q   <= phase_d;
      if (s2_free) begin
        s2_valid_q <= issue;
      end
      if (s2_fire && s2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_kind_q        <= head_ctrl_i.kind;
      s2_last_q        <= issue_last;
      s2_addr_q        <= issue_addr;
      s2_bypass_q      <= wr_en && (wr_addr == issue_addr);
      s2_bypass_data_q <= wr_data;
      s2_wf_q          <= head_ctrl_i.window_full;
      s2_fwd_q         <= head_fwd_i;
      s2_rev_q         <= head_rev_i;
    end
    if (s2_fire && s2_last_q) begin
      out_wf_q    <= s2_wf_q;
      // a read carries its bin address in the forward slot; report it as zero
      out_fwd_q   <= s2_wf_q ? s2_fwd_q : '0;
      out_rev_q   <= s2_wf_q ? s2_rev_q : '0;
      out_count_q <= (s2_kind_q == CMD_READ) ? eff : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_window_full_o = out_wf_q;
  assign out_fwd_o         = out_fwd_q;
  assign out_rev_o         = out_rev_q;
  assign out_count_o       = out_count_q;

  `KMC_NEVER(a_no_read_in_clear, clk_i, rst_ni, state_q == ST_CLEAR && rd_en)
  `KMC_ASSERT(a_phase_on_double, clk_i, rst_ni, phase_q |-> (head_valid_i && double_op))
  `KMC_ASSERT(a_stall_keeps_stage, clk_i, rst_ni, (s2_valid_q && !s2_fire) |=> (s2_valid_q && $stable(s2_addr_q)))
  `KMC_ASSERT(a_read_ends_item, clk_i, rst_ni, (s2_valid_q && s2_kind_q == CMD_READ) |-> s2_last_q)

endmodule

// File: verif/kmc_result_checker.sv
`timescale 1ns / 1ps

module kmc_result_checker import kmc_pkg::*; #(
  parameter int unsigned MAX_KMER = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic                   opcode_i,
  input  logic [BYTE_W-1:0]      stream_byte_i,
  input  logic [ADDR_IN_W-1:0]   bin_address_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   window_full_i,
  input  logic [IDX_OUT_W-1:0]   forward_index_i,
  input  logic [IDX_OUT_W-1:0]   reverse_index_i,
  input  logic [COUNT_OUT_W-1:0] bin_count_i,
  output int unsigned            pending_o,
  output int unsigned            failures_o
);

  localparam int unsigned WinW  = 2 * MAX_KMER;
  localparam int unsigned Depth = 1 << WinW;

  typedef struct packed {
    logic                   window_full;
    logic [IDX_OUT_W-1:0]   forward_index;
    logic [IDX_OUT_W-1:0]   reverse_index;
    logic [COUNT_OUT_W-1:0] bin_count;
  } kmer_result_t;

  logic [COUNT_OUT_W-1:0] kmer_bins [Depth];
  logic [WinW-1:0]        fwd_bases;
  logic [WinW-1:0]        rc_bases;
  int unsigned            run_len;
  logic                   in_header;
  logic [KLEN_W-1:0]      kmer_len;
  logic                   count_rc;
  int unsigned            fail_n;
  kmer_result_t           expected_counts_q [$];

  // -1 for anything that is not a nucleotide letter
  function automatic int nucleotide(input logic [BYTE_W-1:0] ch);
    case (ch)
      "A", "a": return 0;
      "C", "c": return 1;
      "G", "g": return 2;
      "T", "t": return 3;
      default:  return -1;
    endcase
  endfunction

  function automatic void restart_window();
    fwd_bases = '0;
    rc_bases  = '0;
    run_len   = 0;
  endfunction

  function automatic void bump_bin(input logic [WinW-1:0] idx);
    if (kmer_bins[idx] != '1) kmer_bins[idx] = kmer_bins[idx] + 1'b1;
  endfunction

  function automatic kmer_result_t count_kmer(input logic op, input logic [BYTE_W-1:0] ch,
                                              input logic [ADDR_IN_W-1:0] addr);
    kmer_result_t r;
    int           code;
    int unsigned  k;
    logic [31:0]  mask;
    r = '0;
    if (opcode_e'(op) == OP_READ) begin
      r.bin_count = kmer_bins[addr[WinW-1:0]];
      return r;
    end
    if (in_header) begin
      if (ch == CH_NEWLINE) in_header = 1'b0;
      return r;
    end
    if (ch == CH_HEADER) begin
      in_header = 1'b1;
      restart_window();
      return r;
    end
    if (ch == CH_NEWLINE) return r;
    code = nucleotide(ch);
    if (code < 0) begin
      restart_window();
      return r;
    end
    fwd_bases = {fwd_bases[WinW-3:0], code[1:0]};
    rc_bases  = {~code[1:0], rc_bases[WinW-1:2]};
    if (run_len < MAX_KMER) run_len++;
    if (kmer_len == 0) k = 1;
    else if (kmer_len > MAX_KMER) k = MAX_KMER;
    else k = kmer_len;
    if (run_len >= k) begin
      mask            = (32'd1 << (2 * k)) - 1;
      r.window_full   = 1'b1;
      r.forward_index = IDX_OUT_W'(fwd_bases & mask[WinW-1:0]);
      r.reverse_index = IDX_OUT_W'(rc_bases >> (2 * (MAX_KMER - k)));
      bump_bin(r.forward_index[WinW-1:0]);
      if (count_rc) bump_bin(r.reverse_index[WinW-1:0]);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    kmer_result_t want;
    kmer_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) kmer_bins[i] = '0;
      restart_window();
      in_header = 1'b0;
      kmer_len  = KLEN_RESET;
      count_rc  = 1'b0;
      fail_n    = 0;
      expected_counts_q.delete();
      pending_o  <= 0;
      failures_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_KMER_LENGTH) kmer_len = cfg_data_i[KLEN_W-1:0];
        else if (cfg_index_i == REG_COUNT_REVERSE) count_rc = cfg_data_i[0];
      end
      if (out_valid_i && out_ready_i) begin
        got = {window_full_i, forward_index_i, reverse_index_i, bin_count_i};
        if (expected_counts_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: result with none pending: full=%0b fwd=%h rev=%h count=%0d",
                     $realtime, got.window_full, got.forward_index, got.reverse_index,
                     got.bin_count);
        end else begin
          want = expected_counts_q.pop_front();
          if (got.window_full !== want.window_full || got.forward_index !== want.forward_index
              || got.reverse_index !== want.reverse_index || got.bin_count !== want.bin_count)
          begin
            fail_n++;
            if (fail_n <= 10) begin
              $display("%0t: mismatch exp full=%0b fwd=%h rev=%h count=%0d", $realtime,
                       want.window_full, want.forward_index, want.reverse_index,
                       want.bin_count);
              $display("%0t:          got full=%0b fwd=%h rev=%h count=%0d", $realtime,
                       got.window_full, got.forward_index, got.reverse_index, got.bin_count);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_counts_q.push_back(count_kmer(opcode_i, stream_byte_i, bin_address_i));
      pending_o  <= expected_counts_q.size();
      failures_o <= fail_n;
    end
  end

endmodule

// File: verif/dna_kmer_histogram_counter_unit_tb.sv
`timescale 1ns / 1ps

module dna_kmer_histogram_counter_unit_tb;
  import kmc_pkg::*;

  localparam int unsigned MaxKmer      = 8;
  // the reset clearing sweep alone visits all 4**MaxKmer bins
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned IdlePct      = 22;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 64;
  localparam int unsigned NumPhases    = 8;
  localparam logic [31:0] BaseLetters  = "ACGT";

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic                   opcode      = 1'b0;
  logic [BYTE_W-1:0]      stream_byte = '0;
  logic [ADDR_IN_W-1:0]   bin_address = '0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic                   window_full;
  logic [IDX_OUT_W-1:0]   forward_index;
  logic [IDX_OUT_W-1:0]   reverse_index;
  logic [COUNT_OUT_W-1:0] bin_count;

  int unsigned pending;
  int unsigned failures;
  int unsigned cycles = 0;

  // stimulus shaping only, never used for checking
  bit                     steady      = 1'b0;  // no idling on either side
  bit                     hdr_mode    = 1'b0;  // stream is inside a header line
  int unsigned            cur_k       = 4;     // effective k-mer length in force
  int unsigned            counted     = 0;     // transfers that the block acts on
  logic [2*MaxKmer-1:0]   recent_kmer = '0;    // last bases fed, to aim reads at live bins

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("dna_kmer_histogram_counter_unit regression: fail");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  dna_kmer_histogram_counter_unit #(
    .MAX_KMER  (MaxKmer),
    .COUNT_BITS(32)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .stream_byte_i  (stream_byte),
    .bin_address_i  (bin_address),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .window_full_o  (window_full),
    .forward_index_o(forward_index),
    .reverse_index_o(reverse_index),
    .bin_count_o    (bin_count)
  );

  kmc_result_checker #(
    .MAX_KMER(MaxKmer)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .opcode_i       (opcode),
    .stream_byte_i  (stream_byte),
    .bin_address_i  (bin_address),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .window_full_i  (window_full),
    .forward_index_i(forward_index),
    .reverse_index_i(reverse_index),
    .bin_count_i    (bin_count),
    .pending_o      (pending),
    .failures_o     (failures)
  );

  // one item transfer; returns on the edge that accepts it, valid still high
  task automatic send_item(input opcode_e op, input logic [BYTE_W-1:0] ch,
                           input logic [ADDR_IN_W-1:0] addr);
    if (!steady) begin
      while ($urandom_range(0, 99) < IdlePct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    stream_byte <= ch;
    bin_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic feed(input logic [BYTE_W-1:0] ch);
    // header bytes and in-sequence newlines are only skipped by the block
    if (!hdr_mode && ch != CH_NEWLINE) counted++;
    if (!hdr_mode && ch == CH_HEADER) hdr_mode = 1'b1;
    else if (hdr_mode && ch == CH_NEWLINE) hdr_mode = 1'b0;
    send_item(OP_FEED, ch, ADDR_IN_W'($urandom));
  endtask

  task automatic read_bin(input logic [ADDR_IN_W-1:0] addr);
    counted++;
    send_item(OP_READ, BYTE_W'($urandom), addr);
  endtask

  // random nucleotide in random case
  task automatic feed_base();
    int unsigned c;
    logic [7:0]  letter;
    c      = $urandom_range(0, 3);
    letter = BaseLetters[8*(3-c) +: 8];
    if ($urandom_range(0, 1) == 1) letter = letter | 8'h20;
    if (!hdr_mode) recent_kmer = {recent_kmer[2*MaxKmer-3:0], c[1:0]};
    feed(letter);
  endtask

  // lower valid, wait for every pending result, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] klen, input logic [CFG_DATA_W-1:0] rc);
    wait_idle();
    cfg_write(REG_KMER_LENGTH, klen);
    cfg_write(REG_COUNT_REVERSE, rc);
    if (klen == 0) cur_k = 1;
    else if (klen > MaxKmer) cur_k = MaxKmer;
    else cur_k = klen;
  endtask

  // mostly well-formed fasta with random content, some junk and reads
  task automatic random_item();
    int unsigned          pick;
    logic [ADDR_IN_W-1:0] mask;
    pick = $urandom_range(0, 99);
    mask = ADDR_IN_W'((32'd1 << (2 * cur_k)) - 1);
    if (pick < 12) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) read_bin(recent_kmer & mask);
      else if (pick < 7) read_bin(ADDR_IN_W'($urandom) & mask);
      else read_bin(ADDR_IN_W'($urandom));
    end else if (hdr_mode) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) feed(CH_NEWLINE);
      else if (pick < 3) feed(CH_HEADER);
      else feed(BYTE_W'($urandom_range(32, 126)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 78) feed_base();
      else if (pick < 83) feed(CH_NEWLINE);
      else if (pick < 87) feed(CH_HEADER);
      else if (pick < 93) feed($urandom_range(0, 1) ? "N" : "n");
      else feed(BYTE_W'($urandom));
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] phase_klen [NumPhases];
    logic [CFG_DATA_W-1:0] phase_rc   [NumPhases];
    bit                    paused;
    // extremes of k (0 and 15 clamp), reverse strand with upper data bits set
    phase_klen = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8};
    phase_rc   = '{4'h1, 4'hF, 4'hE, 4'h1, 4'h0, 4'hF, 4'h0, 4'h0};
    paused     = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings: k of 4, forward strand only
    read_bin(16'hFFFF);
    feed("A");
    feed("c");
    feed("G");
    feed("t");           // first full window
    feed(CH_NEWLINE);    // newline inside a sequence is skipped
    feed("A");           // window carries on across it
    feed("N");           // junk restarts the window
    feed("T");
    feed("T");
    feed("T");
    feed(CH_HEADER);     // header restarts the window too
    feed("A");
    feed(CH_HEADER);     // a second marker inside a header is ignored
    feed("G");
    feed(CH_NEWLINE);    // ends the header
    feed("T");
    feed("T");
    feed("T");
    feed("T");
    feed(8'h00);
    feed(8'hFF);
    read_bin(16'h001B);  // acgt
    read_bin(16'h00FF);  // tttt
    read_bin(16'h006C);  // cgta

    for (int p = 0; p < NumPhases; p++) begin
      set_config(phase_klen[p], phase_rc[p]);
      steady  = (p == 2);
      counted = 0;
      while (counted < PhaseItems) begin
        random_item();
        // sender holds off once until the block has drained completely
        if (p == 4 && !paused && counted >= PhaseItems / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end
    steady = 1'b0;
    wait_idle();

    if (failures == 0) begin
      $display("dna_kmer_histogram_counter_unit regression: pass");
    end else begin
      $display("dna_kmer_histogram_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: dna_kmer_histogram_counter_unit.f
+incdir+rtl
rtl/kmc_pkg.sv
rtl/kmc_ram.sv
rtl/kmc_fifo.sv
rtl/kmc_front.sv
rtl/kmc_back.sv
rtl/dna_kmer_histogram_counter_unit.sv
verif/kmc_result_checker.sv
verif/dna_kmer_histogram_counter_unit_tb.sv
